// File: sv/aes_bm_pkg.sv
package aes_bm_pkg;

  localparam int BlockBytes = 16;
  localparam int NumRounds = 10;
  localparam int RkWords = 2 * (NumRounds + 1);

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4,
    MODE_RSV5    = 3'd5,
    MODE_RSV6    = 3'd6,
    MODE_RSV7    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_KEY_HI  = 3'd1,
    REG_KEY_LO  = 3'd2,
    REG_IV_HI   = 3'd3,
    REG_IV_LO   = 3'd4,
    REG_NONCE   = 3'd5,
    REG_NONE6   = 3'd6,
    REG_NONE7   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic [4:0]  valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       exp_start;
    logic       exp_step;
    logic       load;
    logic       round;
    logic [3:0] rnd;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_round;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // GF(2^8) multiply, reduction polynomial 0x11b
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
      4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
      4'd9: v = 8'h1b; 4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // byte i of a 128-bit block, byte 0 at the top
  function automatic logic [7:0] bget(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[127-8*(w+4*c) -: 8] = sbox(bget(s, w + 4 * ((c + w) % 4)));
    o = t;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = bget(t, 4*c); a1 = bget(t, 4*c+1); a2 = bget(t, 4*c+2); a3 = bget(t, 4*c+3);
        o[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return o;
  endfunction

  // inverse shift rows and inverse sub bytes
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[127-8*(w+4*((c+w)%4)) -: 8] = inv_sbox(bget(s, w + 4*c));
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = bget(s, 4*c); a1 = bget(s, 4*c+1); a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
      o[127-8*(4*c)   -: 8] = gf_mul(a0,8'd14)^gf_mul(a1,8'd11)^gf_mul(a2,8'd13)^gf_mul(a3,8'd9);
      o[127-8*(4*c+1) -: 8] = gf_mul(a0,8'd9)^gf_mul(a1,8'd14)^gf_mul(a2,8'd11)^gf_mul(a3,8'd13);
      o[127-8*(4*c+2) -: 8] = gf_mul(a0,8'd13)^gf_mul(a1,8'd9)^gf_mul(a2,8'd14)^gf_mul(a3,8'd11);
      o[127-8*(4*c+3) -: 8] = gf_mul(a0,8'd11)^gf_mul(a1,8'd13)^gf_mul(a2,8'd9)^gf_mul(a3,8'd14);
    end
    return o;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 8; i++) o[8*i +: 8] = v[63-8*i -: 8];
    return o;
  endfunction

endpackage

// File: sv/aes_bm_ram.sv
module aes_bm_ram #(
  parameter int Width = 128,
  parameter int Depth = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/aes_bm_ctrl.sv
module aes_bm_ctrl import aes_bm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     key_write,
  input  logic     in_fire,
  input  logic     out_fire,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     in_ready,
  output logic     out_valid,
  output logic     cfg_ready
);
  state_t state, state_next;
  logic [3:0] rnd, rnd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd <= '0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    cmd = '0;
    cmd.rnd = rnd;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_ready = 1'b1;
        if (key_write) begin
          cmd.exp_start = 1'b1;
          in_ready = 1'b0;
          rnd_next = 4'd1;
          state_next = ST_EXPAND;
        end else if (in_fire) begin
          cmd.load = 1'b1;
          rnd_next = 4'd0;
          state_next = ST_LOAD;
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        rnd_next = rnd + 4'd1;
        if (rnd == 4'(NumRounds)) state_next = ST_IDLE;
      end
      ST_LOAD: begin
        // first key read in flight
        rnd_next = 4'd1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 4'd1;
        if (stat.last_round) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: sv/aes_bm_dp.sv
module aes_bm_dp import aes_bm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctl_cmd_t   cmd,
  input  logic       cfg_fire,
  input  reg_idx_t   cfg_idx,
  input  logic [63:0] cfg_data,
  input  in_item_t   in_item,
  output out_item_t  out_item,
  output dp_stat_t   stat
);
  mode_t       mode;
  logic [127:0] key, iv, chain, st, kw, din, exp_key, key_new;
  logic [63:0] nonce, counter;
  logic [4:0]  nbytes;
  logic [127:0] rk_rdata, rk_wdata;
  logic [3:0]  rk_raddr, rk_waddr, rnd_la;
  logic        rk_we, dec;
  logic [127:0] rnd_out, blk_in, ks, res;

  assign dec = (mode == MODE_ECB_DEC) || (mode == MODE_CBC_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ECB_ENC;
      key <= '0;
      iv <= '0;
      nonce <= '0;
      chain <= '0;
      counter <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_idx)
          REG_MODE:   mode <= mode_t'(cfg_data[2:0]);
          REG_KEY_HI: key[127:64] <= cfg_data;
          REG_KEY_LO: key[63:0] <= cfg_data;
          REG_IV_HI:  iv[127:64] <= cfg_data;
          REG_IV_LO:  iv[63:0] <= cfg_data;
          REG_NONCE:  nonce <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_item.first_block) begin
        chain <= iv;
        counter <= '0;
      end
      if (cmd.finish) begin
        unique case (mode)
          MODE_CBC_ENC: chain <= rnd_out;
          MODE_CBC_DEC: chain <= din;
          MODE_CTR:     counter <= counter + 64'd1;
          default: ;
        endcase
      end
    end
  end

  // the schedule starts from the key with the half being written merged in
  always_comb begin
    key_new = key;
    if (cfg_fire && cfg_idx == REG_KEY_HI) key_new[127:64] = cfg_data;
    if (cfg_fire && cfg_idx == REG_KEY_LO) key_new[63:0] = cfg_data;
  end

  // key expansion walker: one round key a cycle into the RAM
  always_ff @(posedge clk) begin
    if (cmd.exp_start) kw <= key_new;
    else if (cmd.exp_step) kw <= exp_key;
  end
  assign exp_key = next_rkey(kw, cmd.rnd);

  // registered read: fetch the key for the next round in the cycle before it is needed
  always_comb begin
    rk_we = cmd.exp_start || cmd.exp_step;
    rk_waddr = cmd.exp_start ? 4'd0 : cmd.rnd;
    rk_wdata = cmd.exp_start ? key_new : exp_key;
    rnd_la = (cmd.rnd >= 4'(NumRounds)) ? 4'(NumRounds) : cmd.rnd + 4'd1;
    if (cmd.load) rk_raddr = dec ? 4'(NumRounds) : 4'd0;
    else rk_raddr = dec ? 4'(NumRounds) - rnd_la : rnd_la;
  end

  aes_bm_ram #(.Width(128), .Depth(NumRounds + 1)) u_rk (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_rdata)
  );

  always_comb begin
    priority case (mode)
      MODE_CTR:     blk_in = {bswap64(nonce), bswap64(counter)};
      MODE_CBC_ENC: blk_in = din ^ chain;
      default:      blk_in = din;
    endcase
  end

  always_comb begin
    if (dec) begin
      rnd_out = dec_sub(st) ^ rk_rdata;
      if (cmd.rnd != 4'(NumRounds)) rnd_out = inv_mix(rnd_out);
    end else begin
      rnd_out = enc_round(st, cmd.rnd == 4'(NumRounds)) ^ rk_rdata;
    end
  end

  assign stat.last_round = cmd.round && (cmd.rnd == 4'(NumRounds));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      din <= {in_item.block_high, in_item.block_low};
      nbytes <= (in_item.valid_bytes == 5'd0 || in_item.valid_bytes > 5'(BlockBytes))
                ? 5'(BlockBytes) : in_item.valid_bytes;
    end
    if (cmd.rnd == 4'd0 && !cmd.round && !cmd.load && !cmd.exp_step) st <= blk_in ^ rk_rdata;
    else if (cmd.round) st <= rnd_out;
  end

  always_comb begin
    ks = rnd_out;
    unique case (mode)
      MODE_CBC_DEC: res = ks ^ chain;
      MODE_CTR: begin
        res = ks ^ din;
        for (int i = 0; i < BlockBytes; i++)
          if (5'(i) >= nbytes) res[127-8*i -: 8] = 8'h00;
      end
      default: res = ks;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stat.last_round) begin
      out_item.result_high <= res[127:64];
      out_item.result_low <= res[63:0];
      out_item.result_bytes <= (mode == MODE_CTR) ? nbytes : 5'(BlockBytes);
    end
  end
endmodule

// File: sv/aes128_block_modes.sv
// AES-128 block engine: ECB enc/dec, CBC enc/dec and CTR.
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data), in (in_valid/in_ready,
// in_data) and out (out_valid/out_ready, out_data), all valid/ready.
// cfg_ready is high only while the engine is idle. A write of either key half
// starts the key schedule, one round key a cycle into a small RAM,
// during which no beat is taken on any channel.
// A beat accepted on in goes through the initial key add, while the first round
// key is read, and then ten rounds through one shared round unit before its
// result shows on out. One block at a time: no new beat is taken on in until
// the result has been taken on out.
// When out_ready is low the result holds in the output register and in_ready
// stays low until it is taken.
// Reset (rst, synchronous) clears mode, key, IV, nonce, chaining and counter;
// round keys are not valid until a key half is written.
module aes128_block_modes import aes_bm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
  ctl_cmd_t cmd, cmd_dp;
  dp_stat_t stat;
  logic     cfg_fire, in_fire, out_fire, key_write;
  logic     load_d;

  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign key_write = cfg_fire &&
                     (reg_idx_t'(cfg_index) == REG_KEY_HI || reg_idx_t'(cfg_index) == REG_KEY_LO);

  always_ff @(posedge clk) begin
    if (rst) load_d <= 1'b0;
    else load_d <= cmd.load;
  end

  // finish fires with the last round; the datapath samples the key at rnd 0 after load
  always_comb begin
    cmd_dp = cmd;
    cmd_dp.finish = stat.last_round;
    cmd_dp.rnd = load_d ? 4'd0 : cmd.rnd;
  end

  aes_bm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .key_write(key_write), .in_fire(in_fire),
    .out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(in_ready),
    .out_valid(out_valid), .cfg_ready(cfg_ready)
  );

  aes_bm_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd_dp), .cfg_fire(cfg_fire),
    .cfg_idx(reg_idx_t'(cfg_index)), .cfg_data(cfg_data), .in_item(in_data),
    .out_item(out_data), .stat(stat)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready && !cfg_ready) else $error("accept while result pending");
  a_out_after_last: assert property (@(posedge clk) disable iff (rst)
    stat.last_round |=> out_valid) else $error("result missing after last round");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
endmodule

// File: verif/tb_aes128_block_modes.sv
`timescale 1ns / 100ps

module tb_aes128_block_modes;
  import aes_bm_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  aes128_block_modes dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the engine's registers and chaining state
  logic [7:0] sb_tab [256];
  logic [7:0] isb_tab [256];
  logic [127:0] rkey [11];
  logic [2:0] cur_mode = '0;
  logic [63:0] key_hi = '0, key_lo = '0, iv_hi = '0, iv_lo = '0, nonce_r = '0;
  logic [127:0] chain = '0;
  logic [63:0] ctr_r = '0;

  in_item_t pending_blocks[$];
  out_item_t expected_results[$];
  in_item_t feed_cur = '0;
  bit feed_busy = 0;
  bit gaps_on = 1;
  int gap_left = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

  function automatic void build_sbox();
    logic [7:0] inv, s;
    for (int a = 0; a < 256; a++) begin
      inv = '0;
      for (int b = 1; b < 256; b++)
        if (a != 0 && gfm(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb_tab[a] = s;
      isb_tab[s] = 8'(a);
    end
  endfunction

  function automatic void expand_key();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sb_tab[t[23:16]] ^ rc, sb_tab[t[15:8]], sb_tab[t[7:0]], sb_tab[t[31:24]]};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] cipher(input logic [127:0] p);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3;
    s = p ^ rkey[0];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[127-8*(w+4*c) -: 8] = sb_tab[byte_at(s, w + 4 * ((c + w) % 4))];
      s = t;
      if (r < 10)
        for (int c = 0; c < 4; c++) begin
          a0 = byte_at(t, 4*c); a1 = byte_at(t, 4*c+1);
          a2 = byte_at(t, 4*c+2); a3 = byte_at(t, 4*c+3);
          s[127-8*(4*c) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          s[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          s[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          s[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      s ^= rkey[r];
    end
    return s;
  endfunction

  function automatic logic [127:0] inv_cipher(input logic [127:0] p);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3;
    s = p ^ rkey[10];
    for (int r = 10; r >= 1; r--) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[127-8*(w+4*((c+w)%4)) -: 8] = isb_tab[byte_at(s, w + 4*c)];
      t ^= rkey[r-1];
      s = t;
      if (r > 1)
        for (int c = 0; c < 4; c++) begin
          a0 = byte_at(t, 4*c); a1 = byte_at(t, 4*c+1);
          a2 = byte_at(t, 4*c+2); a3 = byte_at(t, 4*c+3);
          s[127-8*(4*c) -: 8] = gfm(a0, 8'd14) ^ gfm(a1, 8'd11) ^ gfm(a2, 8'd13)
                                ^ gfm(a3, 8'd9);
          s[127-8*(4*c+1) -: 8] = gfm(a0, 8'd9) ^ gfm(a1, 8'd14) ^ gfm(a2, 8'd11)
                                  ^ gfm(a3, 8'd13);
          s[127-8*(4*c+2) -: 8] = gfm(a0, 8'd13) ^ gfm(a1, 8'd9) ^ gfm(a2, 8'd14)
                                  ^ gfm(a3, 8'd11);
          s[127-8*(4*c+3) -: 8] = gfm(a0, 8'd11) ^ gfm(a1, 8'd13) ^ gfm(a2, 8'd9)
                                  ^ gfm(a3, 8'd14);
        end
    end
    return s;
  endfunction

  function automatic out_item_t crypt_block(input in_item_t it);
    out_item_t o;
    logic [127:0] d, s, cb;
    int n;
    d = {it.block_high, it.block_low};
    n = BlockBytes;
    if (it.first_block) begin
      chain = {iv_hi, iv_lo};
      ctr_r = '0;
    end
    case (mode_t'(cur_mode))
      MODE_ECB_DEC: s = inv_cipher(d);
      MODE_CBC_ENC: begin
        s = cipher(d ^ chain);
        chain = s;
      end
      MODE_CBC_DEC: begin
        s = inv_cipher(d) ^ chain;
        chain = d;
      end
      MODE_CTR: begin
        n = it.valid_bytes;
        if (n == 0 || n > BlockBytes) n = BlockBytes;
        // nonce and counter are little-endian in the counter block
        for (int i = 0; i < 8; i++) begin
          cb[127-8*i -: 8] = nonce_r[8*i +: 8];
          cb[63-8*i -: 8] = ctr_r[8*i +: 8];
        end
        s = cipher(cb) ^ d;
        for (int i = 0; i < BlockBytes; i++)
          if (i >= n) s[127-8*i -: 8] = 8'h00;
        ctr_r = ctr_r + 64'd1;
      end
      default: s = cipher(d);
    endcase
    o.result_high = s[127:64];
    o.result_low = s[63:0];
    o.result_bytes = 5'(n);
    return o;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** aes128_block_modes: FAILED **");
      $finish;
    end
  end

  // input beat accepted: predict now, config is stable while items flow
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(crypt_block(in_data));
      feed_busy = 0;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.result_high !== e.result_high) begin
          errors++;
          $display("%0t: result_high exp %h got %h", $time, e.result_high,
                   out_data.result_high);
        end
        if (out_data.result_low !== e.result_low) begin
          errors++;
          $display("%0t: result_low exp %h got %h", $time, e.result_low,
                   out_data.result_low);
        end
        if (out_data.result_bytes !== e.result_bytes) begin
          errors++;
          $display("%0t: result_bytes exp %0d got %0d", $time, e.result_bytes,
                   out_data.result_bytes);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!feed_busy) begin
        if (gap_left > 0) gap_left--;
        else if (pending_blocks.size() > 0) begin
          feed_cur = pending_blocks.pop_front();
          feed_busy = 1;
          gap_left = gaps_on ? pick_gap() : 0;
        end
      end
      in_valid <= feed_busy;
      in_data <= feed_cur;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) hold_cnt--;
      else if (stall_cnt > 0) stall_cnt--;
      else if (gaps_on) stall_cnt = pick_gap();
      out_ready <= (hold_cnt == 0 && stall_cnt == 0);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE: cur_mode = val[2:0];
      REG_KEY_HI: begin key_hi = val; expand_key(); end
      REG_KEY_LO: begin key_lo = val; expand_key(); end
      REG_IV_HI: iv_hi = val;
      REG_IV_LO: iv_lo = val;
      REG_NONCE: nonce_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo,
                             input bit first, input logic [4:0] nb);
    in_item_t it;
    it.block_high = hi;
    it.block_low = lo;
    it.first_block = first;
    it.valid_bytes = nb;
    pending_blocks.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() > 0 || feed_busy || expected_results.size() > 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    write_reg(REG_KEY_HI, 64'h0001020304050607);
    write_reg(REG_KEY_LO, 64'h08090a0b0c0d0e0f);
    write_reg(REG_MODE, 64'(MODE_ECB_ENC));
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 5'd16);
    queue_block('0, '0, 1'b1, 5'd0);
    queue_block('1, '1, 1'b0, 5'd31);
    wait_idle();
    write_reg(REG_MODE, 64'(MODE_ECB_DEC));
    queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0, 5'd3);
    queue_block('1, '0, 1'b1, 5'd16);
    wait_idle();
    // chaining from zero before any iv or first-block marker
    write_reg(REG_MODE, 64'(MODE_CBC_ENC));
    write_reg(REG_IV_HI, 64'hfedcba9876543210);
    write_reg(REG_IV_LO, 64'h0f1e2d3c4b5a6978);
    queue_block(64'h1111111111111111, 64'h2222222222222222, 1'b0, 5'd16);
    queue_block(64'h3333333333333333, 64'h4444444444444444, 1'b1, 5'd16);
    queue_block(64'h5555555555555555, 64'h6666666666666666, 1'b0, 5'd16);
    wait_idle();
    write_reg(REG_MODE, 64'(MODE_CBC_DEC));
    queue_block(64'haaaaaaaaaaaaaaaa, 64'hbbbbbbbbbbbbbbbb, 1'b1, 5'd16);
    queue_block(64'hcccccccccccccccc, 64'hdddddddddddddddd, 1'b0, 5'd16);
    wait_idle();
    write_reg(REG_MODE, 64'(MODE_CTR));
    write_reg(REG_NONCE, 64'h0123456789abcdef);
    queue_block('1, '1, 1'b1, 5'd16);
    queue_block('1, '1, 1'b0, 5'd1);
    queue_block('1, '1, 1'b0, 5'd15);
    queue_block('1, '1, 1'b0, 5'd0);
    queue_block('1, '1, 1'b0, 5'd31);
    queue_block('1, '1, 1'b0, 5'd17);
    queue_block('1, '1, 1'b1, 5'd8);
    wait_idle();
    // reserved modes act as ecb encrypt; unused register indexes are dropped
    write_reg(REG_MODE, 64'(MODE_RSV5));
    write_reg(REG_NONE6, '1);
    write_reg(REG_NONE7, '1);
    queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 5'd16);
    wait_idle();
    write_reg(REG_MODE, 64'(MODE_RSV7));
    queue_block('0, '1, 1'b0, 5'd16);
    wait_idle();
  endtask

  task automatic test_random_phases();
    mode_t m;
    for (int p = 0; p < 14; p++) begin
      gaps_on = (p % 4 != 3);
      m = mode_t'($urandom_range(0, 7));
      write_reg(REG_MODE, 64'(m));
      if (p == 0) begin
        write_reg(REG_KEY_HI, '0);
        write_reg(REG_KEY_LO, '0);
      end else if (p == 1) begin
        write_reg(REG_KEY_HI, '1);
        write_reg(REG_KEY_LO, '1);
      end else begin
        write_reg(REG_KEY_HI, rand_word());
        write_reg(REG_KEY_LO, rand_word());
      end
      write_reg(REG_IV_HI, rand_word());
      write_reg(REG_IV_LO, rand_word());
      write_reg(REG_NONCE, rand_word());
      for (int i = 0; i < 48; i++)
        queue_block(rand_word(), rand_word(), i == 0 || $urandom_range(0, 11) == 0,
                    (m == MODE_CTR && $urandom_range(0, 3) != 0) ?
                      5'd16 : 5'($urandom_range(0, 31)));
      wait_idle();
    end
    gaps_on = 1;
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, 64'(MODE_CBC_ENC));
    hold_req = 400;
    for (int i = 0; i < 12; i++)
      queue_block({$urandom, $urandom}, {$urandom, $urandom}, i == 0, 5'd16);
    wait_idle();
  endtask

  initial begin
    build_sbox();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (errors == 0)
      $display("** aes128_block_modes: PASSED **");
    else
      $display("** aes128_block_modes: FAILED **");
    $finish;
  end

endmodule
